FILE: hw/rtl/bcsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsp_pkg: buzzer cue player shared definitions
// Command, mode and cue codes, the segment record and the constant cue ROM.
// ----------------------------------------------------------------------------
package bcsp_pkg;

  // cap on segments played per cue (1 to 16)
  localparam int MAX_SEGMENTS = 8;

  // input modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  // cue codes
  localparam logic [1:0] CUE_SUCCESS = 2'd0;
  localparam logic [1:0] CUE_ERROR   = 2'd1;
  localparam logic [1:0] CUE_BUSY    = 2'd2;

  // result commands
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_TONE    = 2'd1;
  localparam logic [1:0] CMD_SILENCE = 2'd2;

  // segment kinds
  localparam logic [1:0] KIND_SILENCE = 2'd0;
  localparam logic [1:0] KIND_SWEEP   = 2'd1;
  localparam logic [1:0] KIND_TRILL   = 2'd2;

  localparam logic [2:0] ROM_LAST      = 3'd4;
  localparam logic [8:0] TONE_EXTRA_MS = 9'd5;
  localparam logic [5:0] STEP_NONE     = 6'h3f;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] fa;
    logic [11:0] fb;
    logic [8:0]  dur;
    logic [8:0]  step;
  } seg_t;

  function automatic seg_t mk_seg(input logic [1:0] kind, input logic [11:0] fa,
                                  input logic [11:0] fb, input logic [8:0] dur,
                                  input logic [8:0] step);
    seg_t s;
    s.kind = kind;
    s.fa   = fa;
    s.fb   = fb;
    s.dur  = dur;
    s.step = step;
    return s;
  endfunction

  // constant cue ROM, five segments per cue (three for the busy cue)
  function automatic seg_t seg_rom(input logic [1:0] c, input logic [2:0] i);
    seg_t s;
    s = mk_seg(KIND_SILENCE, 12'd0, 12'd0, 9'd0, 9'd0);
    case (c)
      CUE_SUCCESS: begin
        case (i)
          3'd0:    s = mk_seg(KIND_SWEEP, 12'd1800, 12'd2600, 9'd130, 9'd21);
          3'd1:    s = mk_seg(KIND_SILENCE, 12'd0, 12'd0, 9'd40, 9'd0);
          3'd2:    s = mk_seg(KIND_SWEEP, 12'd2400, 12'd3400, 9'd150, 9'd21);
          3'd3:    s = mk_seg(KIND_SILENCE, 12'd0, 12'd0, 9'd40, 9'd0);
          3'd4:    s = mk_seg(KIND_SWEEP, 12'd3600, 12'd2200, 9'd320, 9'd26);
          default: s = mk_seg(KIND_SILENCE, 12'd0, 12'd0, 9'd0, 9'd0);
        endcase
      end
      CUE_ERROR: begin
        case (i)
          3'd0, 3'd2, 3'd4: s = mk_seg(KIND_TRILL, 12'd2000, 12'd2800, 9'd160, 9'd20);
          3'd1, 3'd3:       s = mk_seg(KIND_SILENCE, 12'd0, 12'd0, 9'd60, 9'd0);
          default:          s = mk_seg(KIND_SILENCE, 12'd0, 12'd0, 9'd0, 9'd0);
        endcase
      end
      CUE_BUSY: begin
        case (i)
          3'd0:    s = mk_seg(KIND_SWEEP, 12'd2200, 12'd3800, 9'd200, 9'd20);
          3'd1:    s = mk_seg(KIND_SILENCE, 12'd0, 12'd0, 9'd40, 9'd0);
          3'd2:    s = mk_seg(KIND_SWEEP, 12'd3800, 12'd2000, 9'd170, 9'd19);
          default: s = mk_seg(KIND_SILENCE, 12'd0, 12'd0, 9'd0, 9'd0);
        endcase
      end
      default: s = mk_seg(KIND_SILENCE, 12'd0, 12'd0, 9'd0, 9'd0);
    endcase
    return s;
  endfunction

  // segments played for a cue, capped
  function automatic logic [4:0] cue_count(input logic [1:0] c);
    logic [4:0] n;
    n = (c == CUE_BUSY) ? 5'd3 : 5'd5;
    if (n > 5'(MAX_SEGMENTS)) n = 5'(MAX_SEGMENTS);
    return n;
  endfunction

  // step time, falling back to the duration
  function automatic logic [8:0] step_of(input seg_t s);
    return (s.step != 9'd0) ? s.step : s.dur;
  endfunction

endpackage

FILE: hw/rtl/buzzer_cue_segment_player.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_cue_segment_player: piezo cue sequencer
// Steps through the segments of a fixed cue on millisecond ticks and issues
// tone or silence commands, with bit-serial divide and multiply.
// ----------------------------------------------------------------------------
// Path: start, stop, idle ticks, segment changes and silence go from S_EVAL to
// S_DONE; a trill step or an unchanged step runs the 9-step serial step divider
// (S_DIV1) and S_PICK; a sweep step adds the 21-step serial frequency divider
// (S_DIV2) and S_FREQ. One item is worked at a time; a finished result waits in
// the pending result registers until the output register is free.
// Reset (rst, synchronous, high) makes the block idle with no cue and no step.
module buzzer_cue_segment_player
  import bcsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [1:0]  cue,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  command,
  output logic [11:0] freq_hz,
  output logic [8:0]  tone_ms,
  output logic        playing
);

  localparam int E_W    = 9;
  localparam int PROD_W = 21;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_FREQ = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]  state;

  // item registers
  logic [1:0]  item_mode;
  logic [1:0]  item_cue;
  logic [31:0] item_now;
  logic [31:0] elapsed;

  // player state
  logic        active;
  logic [1:0]  cue_select;
  logic [2:0]  segment_index;
  logic [31:0] segment_start;
  logic [5:0]  last_step;

  // working segment
  logic [1:0]  kind_q;
  logic [11:0] fa_q;
  logic [11:0] fb_q;
  logic [8:0]  dur_q;
  logic [8:0]  stp_q;
  logic [11:0] span_mag;
  logic        span_neg;

  // serial datapath
  logic [E_W-1:0]    e_sh;
  logic [8:0]        rem1;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] dvd;
  logic [8:0]        rem2;
  logic [4:0]        cnt;

  // pending result
  logic [1:0]  res_command;
  logic [11:0] res_freq;
  logic [8:0]  res_tone;
  logic        res_playing;

  logic        in_take;
  logic        is_start;
  logic [1:0]  nb_cue;
  logic [2:0]  nb_base;
  logic        nb_end;
  seg_t        nb_seg;
  logic [8:0]  nb_stp;
  logic [2:0]  cur_i;
  seg_t        cur_seg;
  logic        seg_due;
  logic [9:0]  sh1;
  logic        ge1;
  logic [9:0]  sh2;
  logic        ge2;
  logic [PROD_W-1:0] prod_next;
  logic signed [22:0] freq_sum;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // decode of the item against the current segment
  always_comb begin
    is_start = (item_mode == MODE_START) && (item_cue inside {[CUE_SUCCESS:CUE_BUSY]});
    nb_cue   = is_start ? item_cue : cue_select;
    nb_base  = is_start ? 3'd0 : segment_index;
    nb_end   = ({2'b00, nb_base} >= cue_count(nb_cue));
    nb_seg   = seg_rom(nb_cue, (nb_base > ROM_LAST) ? ROM_LAST : nb_base);
    nb_stp   = step_of(nb_seg);
    cur_i    = (segment_index == 3'd0) ? 3'd0 : segment_index - 3'd1;
    if (cur_i > ROM_LAST) cur_i = ROM_LAST;
    cur_seg  = seg_rom(cue_select, cur_i);
    seg_due  = (|elapsed[31:E_W]) || (elapsed[E_W-1:0] >= cur_seg.dur);
  end

  // one restoring step of each divider, one shift-add of the multiplier
  always_comb begin
    sh1       = {rem1, e_sh[E_W-1]};
    ge1       = (sh1 >= {1'b0, stp_q});
    sh2       = {rem2, dvd[PROD_W-1]};
    ge2       = (sh2 >= {1'b0, dur_q});
    prod_next = {prod[PROD_W-2:0], 1'b0} +
                (e_sh[E_W-1] ? {{(PROD_W-12){1'b0}}, span_mag} : {PROD_W{1'b0}});
    freq_sum  = $signed({11'd0, fa_q}) +
                (span_neg ? -$signed({2'b00, dvd}) : $signed({2'b00, dvd}));
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      active        <= 1'b0;
      cue_select    <= 2'd0;
      segment_index <= 3'd0;
      segment_start <= 32'd0;
      last_step     <= STEP_NONE;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_take) begin
            item_mode <= mode;
            item_cue  <= cue;
            item_now  <= now_ms;
            elapsed   <= now_ms - segment_start;
            state     <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_DONE;
          if (is_start || (item_mode == MODE_TICK && active && seg_due)) begin
            // load the next segment and fire its first sound, or end the cue when none is left
            if (is_start) begin
              cue_select    <= item_cue;
            end
            if (nb_end) begin
              active      <= 1'b0;
              res_command <= CMD_SILENCE;
              res_freq    <= 12'd0;
              res_tone    <= 9'd0;
              res_playing <= 1'b0;
            end else begin
              active        <= 1'b1;
              segment_index <= nb_base + 3'd1;
              segment_start <= item_now;
              res_playing   <= 1'b1;
              if (nb_seg.kind == KIND_SILENCE) begin
                last_step   <= STEP_NONE;
                res_command <= CMD_SILENCE;
                res_freq    <= 12'd0;
                res_tone    <= 9'd0;
              end else begin
                last_step   <= 6'd0;
                res_command <= CMD_TONE;
                res_freq    <= nb_seg.fa;
                res_tone    <= nb_stp + TONE_EXTRA_MS;
              end
            end
          end else if (item_mode != MODE_TICK) begin
            active      <= 1'b0;
            res_command <= CMD_SILENCE;
            res_freq    <= 12'd0;
            res_tone    <= 9'd0;
            res_playing <= 1'b0;
          end else if (!active || cur_seg.kind == KIND_SILENCE) begin
            res_command <= CMD_NONE;
            res_freq    <= 12'd0;
            res_tone    <= 9'd0;
            res_playing <= active;
          end else begin
            kind_q   <= cur_seg.kind;
            fa_q     <= cur_seg.fa;
            fb_q     <= cur_seg.fb;
            dur_q    <= cur_seg.dur;
            stp_q    <= step_of(cur_seg);
            span_neg <= (cur_seg.fb < cur_seg.fa);
            span_mag <= (cur_seg.fb < cur_seg.fa) ? cur_seg.fa - cur_seg.fb
                                                  : cur_seg.fb - cur_seg.fa;
            e_sh     <= elapsed[E_W-1:0];
            rem1     <= 9'd0;
            prod     <= {PROD_W{1'b0}};
            cnt      <= 5'(E_W - 1);
            state    <= S_DIV1;
          end
        end
        S_DIV1: begin
          // step index and span * elapsed, one elapsed bit a cycle
          rem1  <= ge1 ? 9'(sh1 - {1'b0, stp_q}) : sh1[8:0];
          e_sh  <= {e_sh[E_W-2:0], ge1};
          prod  <= prod_next;
          cnt   <= cnt - 5'd1;
          if (cnt == 5'd0) state <= S_PICK;
        end
        S_PICK: begin
          state       <= S_DONE;
          res_playing <= 1'b1;
          if (e_sh[5:0] == last_step) begin
            res_command <= CMD_NONE;
            res_freq    <= 12'd0;
            res_tone    <= 9'd0;
          end else begin
            last_step   <= e_sh[5:0];
            res_command <= CMD_TONE;
            res_tone    <= stp_q + TONE_EXTRA_MS;
            if (kind_q == KIND_TRILL) begin
              res_freq <= e_sh[0] ? fb_q : fa_q;
            end else begin
              dvd   <= prod;
              rem2  <= 9'd0;
              cnt   <= 5'(PROD_W - 1);
              state <= S_DIV2;
            end
          end
        end
        S_DIV2: begin
          // |span * elapsed| / duration, one quotient bit a cycle
          rem2 <= ge2 ? 9'(sh2 - {1'b0, dur_q}) : sh2[8:0];
          dvd  <= {dvd[PROD_W-2:0], ge2};
          cnt  <= cnt - 5'd1;
          if (cnt == 5'd0) state <= S_FREQ;
        end
        S_FREQ: begin
          // interpolated frequency, clamped to the output range
          if (freq_sum < 0) res_freq <= 12'd0;
          else if (freq_sum > 23'sd4095) res_freq <= 12'hfff;
          else res_freq <= freq_sum[11:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            command   <= res_command;
            freq_hz   <= res_freq;
            tone_ms   <= res_tone;
            playing   <= res_playing;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_tone_while_playing: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == CMD_TONE |-> playing)
    else $error("tone command issued with no cue playing");

  a_active_has_segment: assert property (@(posedge clk) disable iff (rst)
    active |-> segment_index != 3'd0)
    else $error("cue active with no segment loaded");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result presented outside the hand-off state");

  a_div2_sweep_only: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV2 |-> kind_q == KIND_SWEEP)
    else $error("frequency divider running for a non-sweep segment");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: buzzer_cue_segment_player testbench
// Drives start, stop and millisecond tick items through the valid/stall input
// channel, takes each expected result from a local cue player model or a directed row and checks
// each result field by field under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb;
  import bcsp_pkg::*;

  // codes with no named meaning in the package
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] CUE_NONE    = 2'd3;

  localparam int RANDOM_PER_PHASE = 450;
  localparam int HOLD_CYCLES      = 300;
  localparam int QUIET_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 40;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] freq;
    logic [8:0]  tone;
    logic        playing;
  } cue_result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] fa;
    logic [11:0] fb;
    logic [8:0]  dur;
    logic [8:0]  stp;
  } cue_seg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  cue;
    logic [31:0] now;
    logic        fixed;
    cue_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_TICK;
  logic [1:0]  cue = CUE_SUCCESS;
  logic [31:0] now_ms = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  command;
  logic [11:0] freq_hz;
  logic [8:0]  tone_ms;
  logic        playing;

  // predictor state
  logic        cue_active = 1'b0;
  logic [1:0]  cue_sel = CUE_SUCCESS;
  logic [2:0]  seg_next = 3'd0;
  logic [31:0] seg_start_ms = 32'd0;
  logic [5:0]  step_seen = STEP_NONE;

  cue_result_t expected_q[$];
  stim_row_t   directed_rows[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_request = 1'b0;
  logic [31:0] time_cursor = 32'd0;

  buzzer_cue_segment_player dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .cue       (cue),
    .now_ms    (now_ms),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .command   (command),
    .freq_hz   (freq_hz),
    .tone_ms   (tone_ms),
    .playing   (playing)
  );

  always #4 clk = ~clk;

  // cue segment table, five entries per cue (three for the busy cue)
  function automatic cue_seg_t cue_segment(input logic [1:0] c, input int i);
    cue_seg_t s;
    s = '0;
    if (c == CUE_SUCCESS) begin
      case (i)
        0: s = '{KIND_SWEEP, 12'd1800, 12'd2600, 9'd130, 9'd21};
        2: s = '{KIND_SWEEP, 12'd2400, 12'd3400, 9'd150, 9'd21};
        4: s = '{KIND_SWEEP, 12'd3600, 12'd2200, 9'd320, 9'd26};
        default: s = '{KIND_SILENCE, 12'd0, 12'd0, 9'd40, 9'd0};
      endcase
    end else if (c == CUE_ERROR) begin
      if (i % 2 == 0) s = '{KIND_TRILL, 12'd2000, 12'd2800, 9'd160, 9'd20};
      else s = '{KIND_SILENCE, 12'd0, 12'd0, 9'd60, 9'd0};
    end else if (c == CUE_BUSY) begin
      case (i)
        0: s = '{KIND_SWEEP, 12'd2200, 12'd3800, 9'd200, 9'd20};
        1: s = '{KIND_SILENCE, 12'd0, 12'd0, 9'd40, 9'd0};
        2: s = '{KIND_SWEEP, 12'd3800, 12'd2000, 9'd170, 9'd19};
        default: s = '0;
      endcase
    end
    return s;
  endfunction

  function automatic int cue_length(input logic [1:0] c);
    int n;
    n = (c == CUE_BUSY) ? 3 : 5;
    return (n > MAX_SEGMENTS) ? MAX_SEGMENTS : n;
  endfunction

  function automatic cue_seg_t playing_segment();
    int i;
    i = (seg_next == 3'd0) ? 0 : int'(seg_next) - 1;
    if (i > 4) i = 4;
    return cue_segment(cue_sel, i);
  endfunction

  function automatic logic [8:0] seg_step(input cue_seg_t s);
    return (s.stp != 9'd0) ? s.stp : s.dur;
  endfunction

  // load the next segment and fire its first sound, or end the cue when none is left
  function automatic cue_result_t advance_segment(input logic [31:0] t);
    cue_result_t res;
    cue_seg_t    s;
    res = '0;
    if (int'(seg_next) >= cue_length(cue_sel)) begin
      cue_active = 1'b0;
      res.command = CMD_SILENCE;
    end else begin
      seg_next = seg_next + 3'd1;
      s = playing_segment();
      seg_start_ms = t;
      if (s.kind == KIND_SILENCE) begin
        step_seen = STEP_NONE;
        res.command = CMD_SILENCE;
      end else begin
        step_seen = 6'd0;
        res.command = CMD_TONE;
        res.freq = s.fa;
        res.tone = seg_step(s) + TONE_EXTRA_MS;
      end
    end
    res.playing = cue_active;
    return res;
  endfunction

  // expected buzzer command for one input item
  function automatic cue_result_t predict_cue_output(input logic [1:0] m, input logic [1:0] c,
                                                     input logic [31:0] t);
    cue_result_t res;
    cue_seg_t    s;
    logic [31:0] elapsed;
    logic [31:0] idx;
    logic [8:0]  stp;
    longint      span;
    longint      freq;
    res = '0;
    if (m == MODE_START && c != CUE_NONE) begin
      cue_active = 1'b1;
      cue_sel = c;
      seg_next = 3'd0;
      return advance_segment(t);
    end
    // stop, unused mode, or start of the missing cue
    if (m != MODE_TICK) begin
      cue_active = 1'b0;
      res.command = CMD_SILENCE;
      return res;
    end
    if (!cue_active) return res;
    s = playing_segment();
    elapsed = t - seg_start_ms;
    if (elapsed >= {23'd0, s.dur}) return advance_segment(t);
    res.playing = 1'b1;
    if (s.kind == KIND_SILENCE) return res;
    stp = seg_step(s);
    idx = elapsed / {23'd0, stp};
    if (idx[5:0] == step_seen) return res;
    step_seen = idx[5:0];
    if (s.kind == KIND_TRILL) begin
      freq = idx[0] ? longint'(s.fb) : longint'(s.fa);
    end else begin
      span = longint'(s.fb) - longint'(s.fa);
      freq = longint'(s.fa) + (span * longint'(elapsed)) / longint'(s.dur);
    end
    if (freq < 0) freq = 0;
    if (freq > 4095) freq = 4095;
    res.command = CMD_TONE;
    res.freq = freq[11:0];
    res.tone = stp + TONE_EXTRA_MS;
    return res;
  endfunction

  function automatic cue_result_t mk_result(input logic [1:0] cmd, input int f, input int tm,
                                            input logic p);
    cue_result_t r;
    r.command = cmd;
    r.freq = f[11:0];
    r.tone = tm[8:0];
    r.playing = p;
    return r;
  endfunction

  task automatic add_row(input logic [1:0] m, input logic [1:0] c, input logic [31:0] t,
                         input logic fixed, input cue_result_t want);
    stim_row_t r;
    r.mode = m;
    r.cue = c;
    r.now = t;
    r.fixed = fixed;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  // offer one item, wait for it to be taken, then queue its expected result
  task automatic send_item(input logic [1:0] m, input logic [1:0] c, input logic [31:0] t,
                           input logic fixed, input cue_result_t want);
    cue_result_t pred;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    cue <= c;
    now_ms <= t;
    do @(posedge clk); while (in_stall);
    pred = predict_cue_output(m, c, t);
    expected_q.push_back(fixed ? want : pred);
  endtask

  // random item: mostly well-formed play sequences, some noise
  task automatic next_random_item(output logic [1:0] m, output logic [1:0] c,
                                  output logic [31:0] t);
    int r;
    int d;
    r = $urandom_range(99);
    m = MODE_TICK;
    c = 2'($urandom);
    if (r < 3) begin
      m = MODE_STOP;
    end else if (r < 5) begin
      m = MODE_UNUSED;
    end else if (r < 7) begin
      m = MODE_START;
      c = CUE_NONE;
    end else if (r < 9) begin
      time_cursor = $urandom;
    end else if (r < 11) begin
      // restart just ahead of the time wrap
      time_cursor = 32'hFFFF_FF00 + $urandom_range(255);
      m = MODE_START;
      c = 2'($urandom_range(2));
    end else if (r < 14 || (!cue_active && r < 70)) begin
      m = MODE_START;
      c = 2'($urandom_range(2));
    end else begin
      d = $urandom_range(99);
      if (d < 10) d = 0;
      else if (d < 60) d = $urandom_range(3, 1);
      else if (d < 90) d = $urandom_range(25, 4);
      else d = $urandom_range(400, 26);
      time_cursor = time_cursor + d;
    end
    t = time_cursor;
  endtask

  // result checker and idle-cycle counter for the watchdog
  always @(posedge clk) begin
    cue_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no item waiting: command %0d freq %0d tone %0d playing %0d",
                   $time, command, freq_hz, tone_ms, playing);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (command !== want.command) begin
            $display("%0t: command expected %0d actual %0d", $time, want.command, command);
            mismatch_count = mismatch_count + 1;
          end
          if (freq_hz !== want.freq) begin
            $display("%0t: freq_hz expected %0d actual %0d", $time, want.freq, freq_hz);
            mismatch_count = mismatch_count + 1;
          end
          if (tone_ms !== want.tone) begin
            $display("%0t: tone_ms expected %0d actual %0d", $time, want.tone, tone_ms);
            mismatch_count = mismatch_count + 1;
          end
          if (playing !== want.playing) begin
            $display("%0t: playing expected %0d actual %0d", $time, want.playing, playing);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, with one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("buzzer_cue_segment_player verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [1:0]  m;
    logic [1:0]  c;
    logic [31:0] t;
    cue_result_t none;
    none = '0;

    // idle behavior, illegal codes and extremes
    add_row(MODE_TICK, CUE_SUCCESS, 32'd0, 1'b1, mk_result(CMD_NONE, 0, 0, 1'b0));
    add_row(MODE_STOP, CUE_ERROR, 32'd5, 1'b1, mk_result(CMD_SILENCE, 0, 0, 1'b0));
    add_row(MODE_UNUSED, CUE_NONE, 32'hFFFF_FFFF, 1'b1, mk_result(CMD_SILENCE, 0, 0, 1'b0));
    add_row(MODE_START, CUE_NONE, 32'd7, 1'b1, mk_result(CMD_SILENCE, 0, 0, 1'b0));
    // success cue played through: sweep up, silence, sweep up, silence, sweep down
    add_row(MODE_START, CUE_SUCCESS, 32'd100, 1'b1, mk_result(CMD_TONE, 1800, 26, 1'b1));
    add_row(MODE_TICK, CUE_SUCCESS, 32'd100, 1'b0, none);
    add_row(MODE_TICK, CUE_SUCCESS, 32'd121, 1'b0, none);
    add_row(MODE_TICK, CUE_SUCCESS, 32'd229, 1'b0, none);
    add_row(MODE_TICK, CUE_SUCCESS, 32'd230, 1'b0, none);
    add_row(MODE_TICK, CUE_SUCCESS, 32'd250, 1'b0, none);
    add_row(MODE_TICK, CUE_SUCCESS, 32'd270, 1'b0, none);
    add_row(MODE_TICK, CUE_SUCCESS, 32'd500, 1'b0, none);
    add_row(MODE_TICK, CUE_SUCCESS, 32'd540, 1'b0, none);
    add_row(MODE_TICK, CUE_SUCCESS, 32'd567, 1'b0, none);
    add_row(MODE_TICK, CUE_SUCCESS, 32'd700, 1'b0, none);
    add_row(MODE_TICK, CUE_SUCCESS, 32'd860, 1'b0, none);
    // trill across the time wrap, then restart while playing
    add_row(MODE_START, CUE_ERROR, 32'hFFFF_FFF0, 1'b1, mk_result(CMD_TONE, 2000, 25, 1'b1));
    add_row(MODE_TICK, CUE_ERROR, 32'h0000_0004, 1'b0, none);
    add_row(MODE_TICK, CUE_BUSY, 32'h0000_0018, 1'b0, none);
    add_row(MODE_START, CUE_BUSY, 32'h0000_0019, 1'b1, mk_result(CMD_TONE, 2200, 25, 1'b1));
    add_row(MODE_STOP, CUE_BUSY, 32'h0000_001A, 1'b1, mk_result(CMD_SILENCE, 0, 0, 1'b0));
    // busy cue runs out after three segments
    add_row(MODE_START, CUE_BUSY, 32'd1000, 1'b1, mk_result(CMD_TONE, 2200, 25, 1'b1));
    add_row(MODE_TICK, CUE_BUSY, 32'd1200, 1'b0, none);
    add_row(MODE_TICK, CUE_BUSY, 32'd1240, 1'b0, none);
    add_row(MODE_TICK, CUE_BUSY, 32'd1410, 1'b0, none);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].mode, directed_rows[i].cue, directed_rows[i].now,
                directed_rows[i].fixed, directed_rows[i].want);

    // random phases: no idling with one long hold-off, sender idle, receiver idle, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          hold_request = 1'b1;
        end
        1: begin
          idle_pct = 58;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 58;
        end
        default: begin
          idle_pct = 31;
          stall_pct = 31;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        next_random_item(m, c, t);
        send_item(m, c, t, 1'b0, none);
      end
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("buzzer_cue_segment_player verification clean");
    end else begin
      $display("buzzer_cue_segment_player verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bcsp_pkg.sv
hw/rtl/buzzer_cue_segment_player.sv
verif/tb.sv
